@@ sv/assert_macros.svh @@
// Assertion macros shared by the extractor modules.
// Each use samples on clk_i and is disabled while rst_ni is low.
// Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DFE_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define DFE_ASSERT(lbl, prop, msg)
`define DFE_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

@@ sv/dfe_pkg.sv @@
// Types and constants of the delimited field extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package dfe_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_PATTERN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PATTERN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LENGTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE_LEN = 3'd6;

  typedef struct packed {
    logic [63:0]      key_pattern;
    logic [3:0]       key_length;
    logic [63:0]      start_pattern;
    logic [3:0]       start_length;
    logic [63:0]      stop_pattern;
    logic [3:0]       stop_length;
    logic [CNT_W-1:0] max_value_length;
  } dfe_cfg_t;

  // One queue entry: an optional capture write and an optional end-of-text flush.
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] wr_idx;
    logic [7:0]       data;
    logic             flush;
    logic             ok;
    logic [CNT_W-1:0] count;
  } dfe_op_t;

endpackage
`default_nettype wire

@@ sv/dfe_if.sv @@
// Stream interfaces of the extractor: input text and output items.
// Depends on nothing; valid/ready handshake with payload.
`timescale 1ns / 1ps
`default_nettype none
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       found;
  logic       last;

  modport source (output valid, output value_byte, output byte_valid, output found,
                  output last, input ready);
  modport sink (input valid, input value_byte, input byte_valid, input found,
                input last, output ready);
endinterface
`default_nettype wire

@@ sv/dfe_front.sv @@
// Front end: pattern window and phase tracking, one text byte per cycle while take_i is high.
// Depends on dfe_pkg; emits capture writes and flush requests as dfe_op_t.
`timescale 1ns / 1ps
`default_nettype none
module dfe_front
  import dfe_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES  = 8,
  parameter int unsigned VALUE_CAPACITY = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dfe_cfg_t   cfg_i,
  input  wire logic       take_i,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  output      logic       push_o,
  output      dfe_op_t    op_o
);

  localparam int unsigned     WinW   = 8 * PATTERN_BYTES;
  localparam logic [3:0]       PbLen  = 4'(PATTERN_BYTES);
  localparam logic [CNT_W-1:0] CapLen = CNT_W'(VALUE_CAPACITY);
  localparam logic [CNT_W-1:0] CntMax = '1;

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  function automatic logic [3:0] clip_len(logic [3:0] len);
    return (len > PbLen) ? PbLen : len;
  endfunction

  function automatic logic win_match(logic [WinW-1:0] win, logic [3:0] cnt,
                                     logic [63:0] pat, logic [3:0] len);
    logic ok;
    int   j;
    ok = (len != 4'd0) && (cnt >= len);
    for (int i = 0; i < int'(PATTERN_BYTES); i++) begin
      if (i < int'(len)) begin
        j = int'(PATTERN_BYTES) - int'(len) + i;
        if (win[8*j +: 8] != pat[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [1:0]       phase_q, phase_d;
  logic [WinW-1:0]  win_q, win_d;
  logic [3:0]       pbc_q, pbc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] vlen_q, vlen_d;
  logic [3:0]       start_len, stop_len;
  logic [CNT_W-1:0] lim;
  logic             ok;

  assign start_len = clip_len(cfg_i.start_length);
  assign stop_len  = clip_len(cfg_i.stop_length);
  assign lim       = (cfg_i.max_value_length > CapLen) ? CapLen : cfg_i.max_value_length;

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    pbc_d   = pbc_q;
    cnt_d   = cnt_q;
    vlen_d  = vlen_q;
    ok      = 1'b0;
    op_o        = '0;
    op_o.data   = text_byte_i;
    op_o.wr_idx = cnt_q;
    if (take_i) begin
      if (phase_q != PH_DONE) begin
        win_d = (win_q >> 8) | (WinW'(text_byte_i) << (WinW - 8));
        if (pbc_q < PbLen) pbc_d = pbc_q + 4'd1;
        unique case (phase_q)
          PH_KEY: begin
            if (win_match(win_d, pbc_d, cfg_i.key_pattern, clip_len(cfg_i.key_length))) begin
              win_d = '0;
              pbc_d = '0;
              if (start_len != 4'd0) begin
                phase_d = PH_START;
              end else begin
                cnt_d = '0;
                if (stop_len == 4'd0) begin
                  vlen_d  = '0;
                  phase_d = PH_DONE;
                end else begin
                  phase_d = PH_STOP;
                end
              end
            end
          end
          PH_START: begin
            if (win_match(win_d, pbc_d, cfg_i.start_pattern, start_len)) begin
              win_d = '0;
              pbc_d = '0;
              cnt_d = '0;
              if (stop_len == 4'd0) begin
                vlen_d  = '0;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_STOP;
              end
            end
          end
          PH_STOP: begin
            if (cnt_q < CapLen) op_o.wr = 1'b1;
            if (cnt_q != CntMax) cnt_d = cnt_q + 1'b1;
            if (win_match(win_d, pbc_d, cfg_i.stop_pattern, stop_len)) begin
              vlen_d  = (cnt_d >= CNT_W'(stop_len)) ? cnt_d - CNT_W'(stop_len) : '0;
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      if (end_of_text_i) begin
        ok          = (phase_d == PH_DONE);
        op_o.flush  = 1'b1;
        op_o.ok     = ok;
        op_o.count  = ok ? ((vlen_d > lim) ? lim : vlen_d) : '0;
        phase_d     = PH_KEY;
        win_d       = '0;
        pbc_d       = '0;
        cnt_d       = '0;
        vlen_d      = '0;
      end
    end
  end

  assign push_o   = take_i && (op_o.wr || op_o.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
      win_q   <= '0;
      pbc_q   <= '0;
      cnt_q   <= '0;
      vlen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      pbc_q   <= pbc_d;
      cnt_q   <= cnt_d;
      vlen_q  <= vlen_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/dfe_queue.sv @@
// Two-entry queue of dfe_op_t between front and back end.
// Depends on dfe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfe_queue
  import dfe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire dfe_op_t op_i,
  output      logic    full_o,
  output      logic    valid_o,
  input  wire logic    pop_i,
  output      dfe_op_t op_o
);

  localparam logic [QPTR_W-1:0] PtrLast = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CntFull = QCNT_W'(QDEPTH);

  dfe_op_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `DFE_ASSERT_NEVER(q_overflow_a, push_i && full_o, "push into full queue")
  `DFE_ASSERT_NEVER(q_underflow_a, pop_i && !valid_o, "pop from empty queue")
  `DFE_ASSERT_NEVER(q_count_a, count_q > CntFull, "queue count out of range")

endmodule
`default_nettype wire

@@ sv/dfe_back.sv @@
// Back end: capture memory, end-of-text emission and output register.
// Depends on dfe_pkg and assert_macros.svh; consumes dfe_op_t from the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfe_back
  import dfe_pkg::*;
#(
  parameter int unsigned VALUE_CAPACITY = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       op_valid_i,
  input  wire dfe_op_t    op_i,
  output      logic       op_pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] value_byte_o,
  output      logic       byte_valid_o,
  output      logic       found_o,
  output      logic       last_o
);

  localparam int unsigned IdxW = (VALUE_CAPACITY > 1) ? $clog2(VALUE_CAPACITY) : 1;

  logic [7:0]       mem_q [VALUE_CAPACITY];
  logic             busy_q, ok_q;
  logic [CNT_W-1:0] k_q, cnt_q;
  logic             rd_v_q, rd_status_q, rd_found_q;
  logic [7:0]       rd_data_q;
  logic             out_v_q, out_bv_q, out_found_q, out_last_q;
  logic [7:0]       out_byte_q;
  logic             pop, out_load, can_issue, issue, issue_byte;

  assign pop        = op_valid_i && !busy_q;
  assign out_load   = rd_v_q && (!out_v_q || out_ready_i);
  assign can_issue  = !rd_v_q || out_load;
  assign issue      = busy_q && can_issue;
  assign issue_byte = issue && (k_q < cnt_q);
  assign op_pop_o   = pop;

  always_ff @(posedge clk_i) begin
    if (pop && op_i.wr) mem_q[op_i.wr_idx[IdxW-1:0]] <= op_i.data;
    if (issue_byte) rd_data_q <= mem_q[k_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      rd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop && op_i.flush) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (issue) begin
        if (issue_byte) begin
          k_q <= k_q + 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        rd_v_q <= 1'b1;
      end else if (out_load) begin
        rd_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && op_i.flush) begin
      cnt_q <= op_i.count;
      ok_q  <= op_i.ok;
    end
    if (issue) begin
      rd_status_q <= !issue_byte;
      rd_found_q  <= issue_byte || ok_q;
    end
    if (out_load) begin
      out_byte_q  <= rd_status_q ? 8'd0 : rd_data_q;
      out_bv_q    <= !rd_status_q;
      out_found_q <= rd_found_q;
      out_last_q  <= rd_status_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign value_byte_o = out_byte_q;
  assign byte_valid_o = out_bv_q;
  assign found_o      = out_found_q;
  assign last_o       = out_last_q;

  `DFE_ASSERT_NEVER(k_range_a, busy_q && (k_q > cnt_q), "emit index past count")
  `DFE_ASSERT(flush_busy_a, pop && op_i.flush |=> busy_q, "flush did not start emission")
  `DFE_ASSERT_NEVER(byte_found_a, out_v_q && out_bv_q && !out_found_q,
                    "captured item without found")

endmodule
`default_nettype wire

@@ sv/delimited_field_extractor_core.sv @@
// Top level of the delimited field extractor: config registers, front, queue, back.
// Depends on dfe_pkg, dfe_if, dfe_front, dfe_queue and dfe_back.
`timescale 1ns / 1ps
`default_nettype none
// Takes one text byte per cycle. Each byte is shifted into a single window in the
// front end and matched against the key, start or stop pattern of its phase; only
// captured bytes and the end-of-text byte leave an entry in a two-entry queue. The
// back end drains the queue: a capture entry is written to memory as it is popped,
// an end-of-text entry emits its n stored bytes and the status item at one item
// per cycle while the output is ready, read from the capture memory through a
// registered read and then the output register. Input stalls only while the queue
// is full, so a following text is accepted during emission until two entries
// wait. Configuration writes take effect at once and belong to idle periods.
module delimited_field_extractor_core
  import dfe_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES  = 8,
  parameter int unsigned VALUE_CAPACITY = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  dfe_in_if.sink                     in_i,
  dfe_out_if.source                  out_o
);

  dfe_cfg_t cfg_q;
  logic     take, push, q_full, q_valid, q_pop;
  dfe_op_t  front_op, q_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_pattern      <= '0;
      cfg_q.key_length       <= '0;
      cfg_q.start_pattern    <= '0;
      cfg_q.start_length     <= '0;
      cfg_q.stop_pattern     <= '0;
      cfg_q.stop_length      <= '0;
      cfg_q.max_value_length <= CNT_W'(31);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_PATTERN:   cfg_q.key_pattern      <= cfg_data_i;
        REG_KEY_LENGTH:    cfg_q.key_length       <= cfg_data_i[3:0];
        REG_START_PATTERN: cfg_q.start_pattern    <= cfg_data_i;
        REG_START_LENGTH:  cfg_q.start_length     <= cfg_data_i[3:0];
        REG_STOP_PATTERN:  cfg_q.stop_pattern     <= cfg_data_i;
        REG_STOP_LENGTH:   cfg_q.stop_length      <= cfg_data_i[3:0];
        REG_MAX_VALUE_LEN: cfg_q.max_value_length <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !q_full;
  assign take       = in_i.valid && !q_full;

  dfe_front #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .VALUE_CAPACITY(VALUE_CAPACITY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .take_i       (take),
    .text_byte_i  (in_i.text_byte),
    .end_of_text_i(in_i.end_of_text),
    .push_o       (push),
    .op_o         (front_op)
  );

  dfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .op_o   (q_op)
  );

  dfe_back #(
    .VALUE_CAPACITY(VALUE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .value_byte_o(out_o.value_byte),
    .byte_valid_o(out_o.byte_valid),
    .found_o     (out_o.found),
    .last_o      (out_o.last)
  );

endmodule
`default_nettype wire
